FILE: sv/lcg64_pkg.sv
// shared types, constants and command structs for the permuted lcg generator
`default_nettype none
package lcg64_pkg;

	localparam logic [63:0] MULT_LCG    = 64'h5851_F42D_4C95_7F2D;
	localparam logic [63:0] MULT_OUT    = 64'hAEF1_7502_108E_F2D9;
	localparam logic [63:0] MIX_CONTENT = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] MIX_SCHED   = 64'hD1B5_4A32_D192_ED03;

	// seed 0, content stream, advanced once: state equals the increment
	localparam logic [63:0] RESET_STATE = 64'h3C6E_F372_FE94_F82B;
	localparam logic [63:0] RESET_INC   = 64'h3C6E_F372_FE94_F82B;

	localparam int XSH_BITS = 29;
	localparam int ROT_LSB  = 59;

	localparam int BOUND_W  = 31;
	localparam int DIV_STEPS = 32;   // two quotient bits per step over 64 bits
	localparam int DRAW_LAST = 7;    // six products, one drain, one commit

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_THR_GO,
		ST_THR,
		ST_DRAW,
		ST_TEST,
		ST_REM,
		ST_OUT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		MODE_RAW,
		MODE_BND,
		MODE_SEED
	} mode_t;

	typedef enum logic [1:0] {
		RES_DRAW,
		RES_REM,
		RES_ZERO
	} res_sel_t;

	typedef enum logic {
		DIV_THR,
		DIV_DRAW
	} div_src_t;

	typedef enum logic [2:0] {
		P_LCG_LL,
		P_LCG_LH,
		P_LCG_HL,
		P_MIX_LL,
		P_MIX_LH,
		P_MIX_HL
	} prod_t;

	typedef struct packed {
		logic     take;
		logic     mul_issue;
		prod_t    mul_sel;
		logic     acc_clr;
		logic     draw_commit;
		logic     div_start;
		div_src_t div_src;
		logic     thr_load;
		logic     res_load;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic bound_zero;
		logic div_busy;
		logic div_done;
		logic below_thr;
	} sts_t;

endpackage
`default_nettype wire

FILE: sv/lcg64_permuted_rng_bounded.sv
// top level of the permuted 64-bit lcg generator with bounded draws
// usage:
//   request channel s_axis: tuser is the action (0 raw draw, 1 bounded draw),
//   tdata carries the 31-bit bound; one item at a time is in work
//   result channel m_axis: tdata is the 64-bit value, tuser the bound-zero error
//   config port: cfg_we with cfg_addr 0 writes the seed, 1 the stream kind;
//   either write reseeds and runs one discarded draw (requests held off)
// operation:
//   one draw runs on a single shared 32x32 multiplier (six partial products,
//   one drain, one commit); a raw item returns that draw as its result
//   a bounded item runs the remainder unit twice (at two bits per cycle) around
//   the draw, and each rejected draw is followed by a fresh one
//   a zero bound returns value 0 with error set, state untouched
// reset: seed 0, content stream, state already advanced once; no sweep needed
// stall: the finished result sits in the output register; the block takes the
//   next item meanwhile and only waits at handoff if the register is still full
`default_nettype none
module lcg64_permuted_rng_bounded
	import lcg64_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request item
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [30:0] bound, [31] zero pad
	input  wire logic        s_axis_tuser,   // [0] action
	// result item
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,   // [63:0] value
	output logic             m_axis_tuser,   // [0] error
	// configuration writes
	input  wire logic        cfg_we,
	input  wire logic        cfg_addr,
	input  wire logic [63:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// controller owns the sequencing and the result-valid flag
	lcg64_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.in_valid  (s_axis_tvalid),
		.in_action (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath holds seed, state, increment, the multiplier and the divider
	lcg64_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.in_bound (s_axis_tdata[BOUND_W-1:0]),
		.cmd      (cmd),
		.sts      (sts),
		.value    (m_axis_tdata),
		.error    (m_axis_tuser)
	);

	// a pending result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result register overwritten while full");

	// one item in work at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("second item accepted while first in work");

	// a register write holds off requests while the reseed draw runs
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_axis_tready)
		else $error("request taken during reseed");

	// the remainder unit is only started when free
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider restarted while busy");

endmodule
`default_nettype wire

FILE: sv/lcg64_div.sv
// radix-4 restoring remainder unit, 64-bit dividend by 31-bit divisor
`default_nettype none
module lcg64_div
	import lcg64_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [63:0]          dividend,
	input  wire logic [BOUND_W-1:0]   divisor,
	output logic                      busy,
	output logic                      done,
	output logic [BOUND_W-1:0]        rem
);

	logic [63:0]        n_q;
	logic [BOUND_W-1:0] r_q;
	logic [BOUND_W-1:0] d_q;
	logic [4:0]         cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [BOUND_W:0]   t1, r1, t2, r2;

	// two dependent compare-subtract steps per cycle
	always_comb begin
		t1 = {r_q, n_q[63]};
		r1 = (t1 >= {1'b0, d_q}) ? t1 - {1'b0, d_q} : t1;
		t2 = {r1[BOUND_W-1:0], n_q[62]};
		r2 = (t2 >= {1'b0, d_q}) ? t2 - {1'b0, d_q} : t2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			n_q <= {n_q[61:0], 2'b00};
			r_q <= r2[BOUND_W-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem  = r_q;

endmodule
`default_nettype wire

FILE: sv/lcg64_dp.sv
// datapath: seed registers, lcg state, shared multiplier, divider and result register
`default_nettype none
module lcg64_dp
	import lcg64_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_addr,
	input  wire logic [63:0]        cfg_data,
	input  wire logic [BOUND_W-1:0] in_bound,
	input  wire cmd_t               cmd,
	output sts_t                    sts,
	output logic [63:0]             value,
	output logic                    error
);

	logic [63:0]        seed_q;
	logic               kind_q;
	logic [63:0]        lcg_q;
	logic [63:0]        inc_q;
	logic [BOUND_W-1:0] bound_q;
	logic [63:0]        p_s1;
	prod_t              sel_s1;
	logic               vld_s1;
	logic [63:0]        acc_lcg_q;
	logic [63:0]        acc_mix_q;
	logic [63:0]        draw_q;
	logic [BOUND_W-1:0] thr_q;
	logic [63:0]        value_q;
	logic               error_q;

	logic [63:0]        seed_new;
	logic               kind_new;
	logic [63:0]        mix;
	logic [31:0]        op_a, op_b;
	logic [63:0]        prod;
	logic [127:0]       rot_wide;
	logic [63:0]        draw_new;
	logic [63:0]        div_num;
	logic               div_busy, div_done;
	logic [BOUND_W-1:0] div_rem;

	assign seed_new = cfg_addr ? seed_q : cfg_data;
	assign kind_new = cfg_addr ? cfg_data[0] : kind_q;

	assign mix = lcg_q ^ (lcg_q >> XSH_BITS);

	always_comb begin
		case (cmd.mul_sel)
			P_LCG_LL: begin op_a = lcg_q[31:0];  op_b = MULT_LCG[31:0];  end
			P_LCG_LH: begin op_a = lcg_q[31:0];  op_b = MULT_LCG[63:32]; end
			P_LCG_HL: begin op_a = lcg_q[63:32]; op_b = MULT_LCG[31:0];  end
			P_MIX_LL: begin op_a = mix[31:0];    op_b = MULT_OUT[31:0];  end
			P_MIX_LH: begin op_a = mix[31:0];    op_b = MULT_OUT[63:32]; end
			P_MIX_HL: begin op_a = mix[63:32];   op_b = MULT_OUT[31:0];  end
			default:  begin op_a = '0;           op_b = '0;              end
		endcase
	end

	assign prod = {32'd0, op_a} * {32'd0, op_b};

	// rotate right by the old state's top five bits
	assign rot_wide = {acc_mix_q, acc_mix_q} >> lcg_q[63:ROT_LSB];
	assign draw_new = rot_wide[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			kind_q <= 1'b0;
			lcg_q  <= RESET_STATE;
			inc_q  <= RESET_INC;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.mul_issue;
			if (cfg_we) begin
				seed_q <= seed_new;
				kind_q <= kind_new;
				if (kind_new) begin
					lcg_q <= seed_new ^ MIX_SCHED;
					inc_q <= {seed_new[62:0], 1'b1};
				end else begin
					lcg_q <= seed_new;
					inc_q <= {seed_new[62:0] ^ MIX_CONTENT[62:0], 1'b1};
				end
			end else if (cmd.draw_commit) begin
				lcg_q <= acc_lcg_q + inc_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		p_s1   <= prod;
		sel_s1 <= cmd.mul_sel;
		if (cmd.take) begin
			bound_q <= in_bound;
		end
		if (cmd.acc_clr) begin
			acc_lcg_q <= '0;
			acc_mix_q <= '0;
		end else if (vld_s1) begin
			case (sel_s1)
				P_LCG_LL: acc_lcg_q <= acc_lcg_q + p_s1;
				P_LCG_LH,
				P_LCG_HL: acc_lcg_q <= acc_lcg_q + {p_s1[31:0], 32'd0};
				P_MIX_LL: acc_mix_q <= acc_mix_q + p_s1;
				P_MIX_LH,
				P_MIX_HL: acc_mix_q <= acc_mix_q + {p_s1[31:0], 32'd0};
				default:  acc_lcg_q <= acc_lcg_q;
			endcase
		end
		if (cmd.draw_commit) begin
			draw_q <= draw_new;
		end
		if (cmd.thr_load) begin
			thr_q <= div_rem;
		end
		if (cmd.res_load) begin
			case (cmd.res_sel)
				RES_DRAW: begin value_q <= draw_q;                          error_q <= 1'b0; end
				RES_REM:  begin value_q <= {{(64-BOUND_W){1'b0}}, div_rem}; error_q <= 1'b0; end
				default:  begin value_q <= '0;                              error_q <= 1'b1; end
			endcase
		end
	end

	// 2^64 - bound
	assign div_num = 64'd0 - {{(64-BOUND_W){1'b0}}, bound_q};

	lcg64_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ((cmd.div_src == DIV_THR) ? div_num : draw_q),
		.divisor  (bound_q),
		.busy     (div_busy),
		.done     (div_done),
		.rem      (div_rem)
	);

	assign sts.bound_zero = (in_bound == '0);
	assign sts.div_busy   = div_busy;
	assign sts.div_done   = div_done;
	assign sts.below_thr  = (draw_q < {{(64-BOUND_W){1'b0}}, thr_q});

	assign value = value_q;
	assign error = error_q;

endmodule
`default_nettype wire

FILE: sv/lcg64_ctrl.sv
// controller: sequences draws, divisions, rejection and result handoff
`default_nettype none
module lcg64_ctrl
	import lcg64_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic in_valid,
	input  wire logic in_action,
	output logic      in_ready,
	input  wire logic out_ready,
	output logic      out_valid,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	ctrl_state_t state_q, state_d;
	logic [2:0]  cnt_q, cnt_d;
	mode_t       mode_q, mode_d;
	res_sel_t    sel_q, sel_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			mode_q      <= MODE_RAW;
			sel_q       <= RES_DRAW;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			mode_q  <= mode_d;
			sel_q   <= sel_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE) && !cfg_we;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		mode_d  = mode_q;
		sel_d   = sel_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.take = 1'b1;
					if (!in_action) begin
						mode_d  = MODE_RAW;
						cnt_d   = '0;
						state_d = ST_DRAW;
					end else if (sts.bound_zero) begin
						sel_d   = RES_ZERO;
						state_d = ST_OUT;
					end else begin
						mode_d  = MODE_BND;
						state_d = ST_THR_GO;
					end
				end
			end
			ST_THR_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_src   = DIV_THR;
				state_d       = ST_THR;
			end
			ST_THR: begin
				if (sts.div_done) begin
					cmd.thr_load = 1'b1;
					cnt_d        = '0;
					state_d      = ST_DRAW;
				end
			end
			ST_DRAW: begin
				cmd.mul_issue = (cnt_q < 3'(DRAW_LAST - 1));
				cmd.mul_sel   = prod_t'(cnt_q);
				cmd.acc_clr   = (cnt_q == '0);
				if (cnt_q == 3'(DRAW_LAST)) begin
					cmd.draw_commit = 1'b1;
					case (mode_q)
						MODE_RAW: begin
							sel_d   = RES_DRAW;
							state_d = ST_OUT;
						end
						MODE_BND: state_d = ST_TEST;
						default:  state_d = ST_IDLE;
					endcase
				end else begin
					cnt_d = cnt_q + 3'd1;
				end
			end
			ST_TEST: begin
				if (sts.below_thr) begin
					cnt_d   = '0;
					state_d = ST_DRAW;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_src   = DIV_DRAW;
					state_d       = ST_REM;
				end
			end
			ST_REM: begin
				if (sts.div_done) begin
					sel_d   = RES_REM;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = sel_q;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		// a register write reseeds: restart with one discarded draw
		if (cfg_we) begin
			mode_d  = MODE_SEED;
			cnt_d   = '0;
			state_d = ST_DRAW;
		end
	end

endmodule
`default_nettype wire

FILE: verif/tb.sv
// self-checking testbench for the permuted lcg generator with bounded draws
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// generator constants, kept here so the check does not lean on the design package
	localparam logic [63:0] LCG_MULTIPLIER = 64'h5851_F42D_4C95_7F2D;
	localparam logic [63:0] OUT_MULTIPLIER = 64'hAEF1_7502_108E_F2D9;
	localparam logic [63:0] CONTENT_MIX    = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] SCHEDULE_MIX   = 64'hD1B5_4A32_D192_ED03;
	localparam int          XORSHIFT       = 29;

	// register indexes on the config port
	localparam logic REG_SEED        = 1'b0;
	localparam logic REG_STREAM_KIND = 1'b1;

	// request actions carried in tuser
	localparam logic ACT_RAW     = 1'b0;
	localparam logic ACT_BOUNDED = 1'b1;

	// stream kinds
	localparam logic KIND_CONTENT  = 1'b0;
	localparam logic KIND_SCHEDULE = 1'b1;

	localparam int LIMIT_CYCLES = 600000;
	localparam int SETTLE       = 16;    // room for one reseed draw, with margin
	localparam int LONG_HOLD    = 400;   // long enough to back up several bounded items
	localparam int ITEMS_PER_SETTING = 250;

	typedef struct packed {
		logic        action;
		logic [30:0] bound;
	} request_t;

	typedef struct packed {
		logic [63:0] value;
		logic        error;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_we = 1'b0;
	logic        cfg_addr = 1'b0;
	logic [63:0] cfg_data = '0;

	lcg64_permuted_rng_bounded u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	// our own copy of the generator: registers plus lcg state
	logic [63:0] gen_seed = '0;
	logic        gen_kind = KIND_CONTENT;
	logic [63:0] gen_state;
	logic [63:0] gen_increment;

	request_t pending_requests[$];
	result_t  expected_results[$];
	result_t  oldest_result;

	int  mismatches = 0;
	int  cycle_count = 0;
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	logic stall_trigger = 1'b0;
	int  hold_left = 0;

	// one lcg step; the output is permuted from the old state
	function automatic logic [63:0] next_draw();
		logic [63:0] old;
		logic [63:0] mixed;
		logic [5:0]  rot;
		old = gen_state;
		gen_state = old * LCG_MULTIPLIER + gen_increment;
		mixed = ((old >> XORSHIFT) ^ old) * OUT_MULTIPLIER;
		rot = {1'b0, old[63:59]};
		if (rot == 0)
			return mixed;
		return (mixed >> rot) | (mixed << (7'd64 - rot));
	endfunction

	// reseed from the current registers, burning one draw
	function automatic void reseed_generator();
		logic [63:0] burn;
		if (gen_kind == KIND_SCHEDULE) begin
			gen_state = gen_seed ^ SCHEDULE_MIX;
			gen_increment = {gen_seed[62:0], 1'b1};
		end else begin
			gen_state = gen_seed;
			gen_increment = {gen_seed[62:0] ^ CONTENT_MIX[62:0], 1'b1};
		end
		burn = next_draw();
	endfunction

	// expected result of one accepted request
	function automatic void predict_request(input logic action, input logic [30:0] bound);
		result_t     res;
		logic [63:0] wide_bound;
		logic [63:0] threshold;
		logic [63:0] candidate;
		res.error = 1'b0;
		if (action == ACT_RAW) begin
			res.value = next_draw();
		end else if (bound == '0) begin
			// zero bound flags an error and leaves the state alone
			res.value = '0;
			res.error = 1'b1;
		end else begin
			// reject draws below (2^64 - bound) mod bound so the modulo stays unbiased
			wide_bound = {33'd0, bound};
			threshold = (64'd0 - wide_bound) % wide_bound;
			candidate = next_draw();
			while (candidate < threshold)
				candidate = next_draw();
			res.value = candidate % wide_bound;
		end
		expected_results.push_back(res);
	endfunction

	function automatic request_t random_request();
		request_t req;
		int       pick;
		pick = $urandom_range(9);
		req.action = 1'($urandom_range(1));
		if (pick == 0)
			req.bound = '0;
		else if (pick < 4)
			req.bound = 31'($urandom_range(16, 1));
		else if (pick < 6)
			req.bound = 31'h7FFF_FFFF - 31'($urandom_range(3));
		else
			req.bound = 31'($urandom() >> $urandom_range(31, 1));
		return req;
	endfunction

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// watchdog: a cycle counter bounds the whole run
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// request driver: predicts on every accepted item, then offers the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				predict_request(s_axis_tuser, s_axis_tdata[30:0]);
			// a held item stays up until taken; a new one may follow back to back
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= pending_requests[0].action;
					s_axis_tdata <= {1'b0, pending_requests[0].bound};
					void'(pending_requests.pop_front());
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result receiver: random back-pressure plus an occasional long hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left <= 0;
		end else begin
			if (stall_trigger)
				hold_left <= LONG_HOLD;
			else if (hold_left > 0)
				hold_left <= hold_left - 1;
			m_axis_tready <= !stall_trigger && hold_left <= 1
				&& $urandom_range(99) >= recv_idle_pct;
		end
	end

	// result monitor: every accepted result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				$error("result item with none expected: value %h error %b",
					m_axis_tdata, m_axis_tuser);
				mismatches++;
			end else begin
				oldest_result = expected_results.pop_front();
				if (m_axis_tdata !== oldest_result.value) begin
					$error("value: expected %h, got %h", oldest_result.value, m_axis_tdata);
					mismatches++;
				end
				if (m_axis_tuser !== oldest_result.error) begin
					$error("error: expected %b, got %b", oldest_result.error, m_axis_tuser);
					mismatches++;
				end
			end
		end
	end

	// wait until nothing is queued, on offer or outstanding; sampled mid-cycle
	task automatic wait_drained();
		while (pending_requests.size() > 0 || expected_results.size() > 0 || s_axis_tvalid)
			@(negedge clk);
	endtask

	// register write while idle; the block then runs its reseed draw
	task automatic write_register(input logic addr, input logic [63:0] data);
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (addr == REG_SEED)
			gen_seed = data;
		else
			gen_kind = data[0];
		reseed_generator();
	endtask

	// stream kind write with junk in the unused upper bits
	task automatic write_kind(input logic kind);
		write_register(REG_STREAM_KIND,
			{$urandom, 31'($urandom_range(32'h7FFF_FFFF)), kind});
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		@(posedge clk);
		send_idle_pct <= send_pct;
		recv_idle_pct <= recv_pct;
	endtask

	task automatic queue_random(input int count);
		repeat (count) pending_requests.push_back(random_request());
	endtask

	task automatic queue_request(input logic action, input logic [30:0] bound);
		request_t req;
		req.action = action;
		req.bound = bound;
		pending_requests.push_back(req);
	endtask

	// main sequence
	initial begin
		// power-up registers: seed 0, content stream
		reseed_generator();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		set_idling(38, 67);

		// directed part straight from reset: field extremes, both actions, zero bound
		queue_request(ACT_RAW, 31'd0);
		queue_request(ACT_RAW, 31'h7FFF_FFFF);
		queue_request(ACT_RAW, 31'h5555_5555);
		queue_request(ACT_BOUNDED, 31'd0);
		queue_request(ACT_RAW, 31'd0);
		queue_request(ACT_BOUNDED, 31'd1);
		queue_request(ACT_BOUNDED, 31'd2);
		queue_request(ACT_BOUNDED, 31'd3);
		queue_request(ACT_BOUNDED, 31'd6);
		queue_request(ACT_BOUNDED, 31'h7FFF_FFFF);
		queue_request(ACT_BOUNDED, 31'h7FFF_FFFE);
		queue_request(ACT_BOUNDED, 31'h4000_0000);
		queue_request(ACT_BOUNDED, 31'h2AAA_AAAA);
		queue_request(ACT_BOUNDED, 31'h5555_5555);
		queue_request(ACT_BOUNDED, 31'd0);
		queue_request(ACT_BOUNDED, 31'd0);
		queue_request(ACT_BOUNDED, 31'd1000);
		queue_request(ACT_BOUNDED, 31'h0001_0000);
		queue_request(ACT_RAW, 31'h2AAA_AAAA);
		queue_request(ACT_RAW, 31'd1);
		wait_drained();

		// all-ones seed on the schedule stream
		write_register(REG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
		write_kind(KIND_SCHEDULE);
		queue_random(ITEMS_PER_SETTING);
		wait_drained();

		// random seed, content stream, idling swapped
		write_kind(KIND_CONTENT);
		write_register(REG_SEED, {$urandom, $urandom});
		set_idling(67, 38);
		queue_random(ITEMS_PER_SETTING / 2);
		// receiver holds off while the sender keeps offering, so the input backs up
		@(posedge clk);
		stall_trigger <= 1'b1;
		@(posedge clk);
		stall_trigger <= 1'b0;
		// sender then pauses until every outstanding result is back
		wait_drained();
		queue_random(ITEMS_PER_SETTING / 2);
		wait_drained();

		// zero seed on the schedule stream, no idling
		write_register(REG_SEED, 64'd0);
		write_kind(KIND_SCHEDULE);
		set_idling(0, 0);
		queue_random(ITEMS_PER_SETTING);
		wait_drained();

		// random seed again, kind written after the seed
		write_register(REG_SEED, {$urandom, $urandom});
		write_kind(KIND_SCHEDULE);
		queue_random(ITEMS_PER_SETTING);
		wait_drained();

		// drain margin for anything the block might still emit
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
